@@ rtl/csv_column_extractor_core_assert.svh @@
// ----------------------------------------------------------------------------
// csv_column_extractor_core_assert.svh
// Assertion macros for the checker file of the column extractor.
// ----------------------------------------------------------------------------
`ifndef CSV_COLUMN_EXTRACTOR_CORE_ASSERT_SVH
`define CSV_COLUMN_EXTRACTOR_CORE_ASSERT_SVH

// Checked only while out of reset.
`define CSVX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CSVX_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/csvx_pkg.sv @@
// ----------------------------------------------------------------------------
// csvx_pkg
// Types and constants shared by the CSV column extractor modules.
// ----------------------------------------------------------------------------
package csvx_pkg;

    // Characters with a meaning in CSV text
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_NL    = 8'h0A;

    // Configuration register indexes
    localparam int unsigned CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_COLUMN      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_REPLACEMENT_BYTES  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_REPLACEMENT_LENGTH = 2'd2;
    localparam int unsigned CFG_DATA_W = 32;

    // Job queue between parser and output sequencer
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = 2;

    typedef struct packed {
        logic [15:0] target_column;
        logic [31:0] replacement_bytes;
        logic [2:0]  replacement_length;
    } cfg_t;

    // What the back end has to send for one input item
    typedef enum logic [1:0] {
        JOB_BYTE,   // one byte, passed as is
        JOB_REPL,   // replacement run for a quoted newline
        JOB_ERR     // column missing error
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] data;
    } job_t;

    typedef struct packed {
        logic push;
        job_t job;
    } job_push_t;

endpackage

@@ rtl/csvx_in_if.sv @@
// ----------------------------------------------------------------------------
// csvx_in_if
// Input channel: one raw CSV text byte per item.
// ----------------------------------------------------------------------------
interface csvx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

@@ rtl/csvx_out_if.sv @@
// ----------------------------------------------------------------------------
// csvx_out_if
// Output channel: one extracted byte and its flags per item.
// ----------------------------------------------------------------------------
interface csvx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       column_missing;

    modport source (output valid, output out_byte, output last_of_run,
                    output column_missing, input ready);
    modport sink   (input valid, input out_byte, input last_of_run,
                    input column_missing, output ready);
endinterface

@@ rtl/csvx_front.sv @@
// ----------------------------------------------------------------------------
// csvx_front
// Parser: takes one text byte per cycle while the job queue is not full,
// tracks quoting and the column, and queues a job for every byte that gives output.
// ----------------------------------------------------------------------------
module csvx_front
    import csvx_pkg::*;
#(
    parameter int unsigned COLUMN_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    csvx_in_if.sink          text_in,
    input  logic             queue_full,
    output job_push_t        job_push
);

    localparam int unsigned CMP_W = (COLUMN_BITS > 16) ? COLUMN_BITS : 16;

    logic                   inside_reg, inside_next;
    logic                   pending_reg, pending_next;
    logic                   halted_reg, halted_next;
    logic [COLUMN_BITS-1:0] column_reg, column_next;

    logic             accept;
    logic             emit;
    job_kind_t        kind;
    logic [7:0]       b;
    logic             in_str;
    logic             in_tgt;
    logic [CMP_W-1:0] col_ext;
    logic [CMP_W-1:0] tgt_ext;

    assign text_in.ready = !queue_full;
    assign accept        = text_in.valid && text_in.ready;
    assign b             = text_in.text_byte;
    assign col_ext       = CMP_W'(column_reg);
    assign tgt_ext       = CMP_W'(cfg.target_column);
    assign in_tgt        = (col_ext == tgt_ext);

    // Classify the byte and work out the next parser state
    always_comb
    begin
        inside_next  = inside_reg;
        pending_next = pending_reg;
        halted_next  = halted_reg;
        column_next  = column_reg;
        emit         = 1'b0;
        kind         = JOB_BYTE;
        in_str       = inside_reg;
        if (!halted_reg)
        begin
            if (pending_reg && (b == CH_QUOTE))
            begin
                // doubled quote: one literal quote, still in the string
                pending_next = 1'b0;
                emit         = in_tgt;
            end
            else
            begin
                // a pending quote closes the string before this byte
                in_str       = pending_reg ? 1'b0 : inside_reg;
                pending_next = 1'b0;
                inside_next  = in_str;
                unique case (b)
                    CH_QUOTE:
                    begin
                        if (in_str)
                            pending_next = 1'b1;
                        else
                            inside_next = 1'b1;
                    end
                    CH_COMMA:
                    begin
                        if (in_str)
                            emit = in_tgt;
                        else if (column_reg != {COLUMN_BITS{1'b1}})
                            column_next = column_reg + 1'b1;
                    end
                    CH_NL:
                    begin
                        if (in_str)
                        begin
                            emit = in_tgt && (cfg.replacement_length != 3'd0);
                            kind = JOB_REPL;
                        end
                        else if (tgt_ext > col_ext)
                        begin
                            halted_next = 1'b1;
                            emit        = 1'b1;
                            kind        = JOB_ERR;
                        end
                        else
                        begin
                            column_next = '0;
                            emit        = 1'b1;
                        end
                    end
                    default:
                    begin
                        emit = in_tgt;
                    end
                endcase
            end
        end
    end

    assign job_push.push     = accept && emit;
    assign job_push.job.kind = kind;
    assign job_push.job.data = b;

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg  <= 1'b0;
            pending_reg <= 1'b0;
            halted_reg  <= 1'b0;
            column_reg  <= '0;
        end
        else if (accept)
        begin
            inside_reg  <= inside_next;
            pending_reg <= pending_next;
            halted_reg  <= halted_next;
            column_reg  <= column_next;
        end
    end

endmodule

@@ rtl/csvx_queue.sv @@
// ----------------------------------------------------------------------------
// csvx_queue
// Small job FIFO that decouples the parser from the output sequencer.
// ----------------------------------------------------------------------------
module csvx_queue
    import csvx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  job_push_t job_push,
    output logic      full,
    input  logic      pop,
    output logic      empty,
    output job_t      head
);

    job_t                   mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full    = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = job_push.push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= job_push.job;
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/csvx_back.sv @@
// ----------------------------------------------------------------------------
// csvx_back
// Output sequencer: expands queued jobs into output items and holds them in
// the output register until taken.
// ----------------------------------------------------------------------------
module csvx_back
    import csvx_pkg::*;
#(
    parameter int unsigned MAX_REPLACEMENT = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          empty,
    input  job_t          head,
    output logic          pop,
    csvx_out_if.source    result_out
);

    localparam int unsigned IDX_W = (MAX_REPLACEMENT > 1) ? $clog2(MAX_REPLACEMENT) : 1;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             valid_reg;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic             missing_reg;

    logic       load;
    logic [3:0] idx4;
    logic [3:0] len4;
    logic [3:0] run_len;
    logic [7:0] item_byte;
    logic       item_last;
    logic       item_missing;

    assign load    = !empty && (!valid_reg || result_out.ready);
    assign idx4    = 4'(idx_reg);
    assign len4    = {1'b0, cfg.replacement_length};
    assign run_len = (len4 > 4'(MAX_REPLACEMENT)) ? 4'(MAX_REPLACEMENT) : len4;

    // Build the next item from the head job
    always_comb
    begin
        item_byte    = head.data;
        item_last    = 1'b1;
        item_missing = 1'b0;
        unique case (head.kind)
            JOB_ERR:
            begin
                item_byte    = 8'h00;
                item_missing = 1'b1;
            end
            JOB_REPL:
            begin
                // only four replacement bytes exist, the rest read as zero
                item_byte = (idx4 < 4'd4) ?
                            8'(cfg.replacement_bytes >> {idx4[1:0], 3'b000}) : 8'h00;
                item_last = (idx4 == (run_len - 4'd1));
            end
            default:
            begin
                item_byte = head.data;
            end
        endcase
    end

    assign pop = load && item_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (load)
            idx_next = item_last ? '0 : IDX_W'(idx_reg + 1'b1);
    end

    // Position within a replacement run, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
                valid_reg <= 1'b1;
            else if (result_out.ready)
                valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg    <= item_byte;
            last_reg    <= item_last;
            missing_reg <= item_missing;
        end
    end

    assign result_out.valid          = valid_reg;
    assign result_out.out_byte       = byte_reg;
    assign result_out.last_of_run    = last_reg;
    assign result_out.column_missing = missing_reg;

endmodule

@@ rtl/csv_column_extractor_core.sv @@
// ----------------------------------------------------------------------------
// csv_column_extractor_core
// CSV column extractor: passes the bytes of one column of CSV text, record
// newlines, and replacement bytes for newlines inside quoted strings.
// ----------------------------------------------------------------------------
// Usage:
//   text_in    : one raw text byte per item (valid/ready).
//   result_out : out_byte with last_of_run on the final item caused by an
//                input byte, column_missing on the one error item.
//   cfg_*      : register writes (target column, replacement bytes and
//                length), only while the block is idle.
// Timing: the parser takes one byte every cycle while the queue is not full;
//   an accepted byte is written to the job queue, then to the output register.
//   A plain byte gives one item and a quoted newline up to MAX_REPLACEMENT
//   items; the output sequencer sends one item per cycle while result_out.ready
//   is high, and the parser keeps running into a four-entry job queue.
// Reset: parser state, queue and output clear; registers go to column 0,
//   replacement 0x0A with length 1. After a column error all further input
//   is taken and dropped until reset.
// Stall: the output register holds while result_out.ready is low; the queue
//   fills, and text_in.ready drops once it holds four jobs.
// ----------------------------------------------------------------------------
module csv_column_extractor_core
    import csvx_pkg::*;
#(
    parameter int unsigned MAX_REPLACEMENT = 4,
    parameter int unsigned COLUMN_BITS     = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    csvx_in_if.sink               text_in,
    csvx_out_if.source            result_out,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t      cfg_reg;
    job_push_t job_push;
    job_t      head;
    logic      queue_full;
    logic      queue_empty;
    logic      pop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_column      <= 16'd0;
            cfg_reg.replacement_bytes  <= 32'd10;
            cfg_reg.replacement_length <= 3'd1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_TARGET_COLUMN:      cfg_reg.target_column      <= cfg_wdata[15:0];
                REG_REPLACEMENT_BYTES:  cfg_reg.replacement_bytes  <= cfg_wdata[31:0];
                REG_REPLACEMENT_LENGTH: cfg_reg.replacement_length <= cfg_wdata[2:0];
                default:                ;
            endcase
        end
    end

    csvx_front #(
        .COLUMN_BITS (COLUMN_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .text_in    (text_in),
        .queue_full (queue_full),
        .job_push   (job_push)
    );

    csvx_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_push (job_push),
        .full     (queue_full),
        .pop      (pop),
        .empty    (queue_empty),
        .head     (head)
    );

    csvx_back #(
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .empty      (queue_empty),
        .head       (head),
        .pop        (pop),
        .result_out (result_out)
    );

endmodule

@@ rtl/csvx_checker.sv @@
// ----------------------------------------------------------------------------
// csvx_checker
// Port-level checks on the column extractor, bound to the top level.
// ----------------------------------------------------------------------------
`include "csv_column_extractor_core_assert.svh"

module csvx_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       last_of_run,
    input logic       column_missing
);

    // the error item is a lone zero byte that ends its run
    `CSVX_ASSERT(a_err_shape, out_valid && column_missing |-> last_of_run && (out_byte == 8'h00), "error item malformed")

    // no item is offered straight after the error item is taken
    `CSVX_ASSERT(a_err_final, out_valid && out_ready && column_missing |=> !out_valid, "item after column error")

    // a stalled item keeps its contents
    `CSVX_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_run) && $stable(column_missing), "stalled item changed")

    // no item offered while in reset
    `CSVX_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !out_valid, "item offered in reset")

endmodule

bind csv_column_extractor_core csvx_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (result_out.valid),
    .out_ready      (result_out.ready),
    .out_byte       (result_out.out_byte),
    .last_of_run    (result_out.last_of_run),
    .column_missing (result_out.column_missing)
);
